### rtl/fjr_pkg.sv
// Package for the feeder jam recovery unit: widths, register indexes, codes and defaults.
`default_nettype none
package fjr_pkg;

   localparam int CUR_W     = 16;
   localparam int LIMIT_W   = 15;
   localparam int JAM_CNT_W = 10;
   localparam int HARD_CNT_W = 16;
   localparam int TICKS_W   = 8;
   localparam int MODE_W    = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_JAM_CURRENT_LIMIT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HARD_CURRENT_LIMIT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_JAM_TIME_LIMIT      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HARD_TIME_LIMIT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_PHASE_TICKS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_REVERSE_TICKS = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_WAIT_TICKS    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_FAST_FEED_TICKS     = 3'd7;

   // register defaults
   localparam logic [LIMIT_W-1:0]    DEF_JAM_CURRENT_LIMIT   = 15'd4200;
   localparam logic [LIMIT_W-1:0]    DEF_HARD_CURRENT_LIMIT  = 15'd16000;
   localparam logic [JAM_CNT_W-1:0]  DEF_JAM_TIME_LIMIT      = 10'd500;
   localparam logic [HARD_CNT_W-1:0] DEF_HARD_TIME_LIMIT     = 16'd100;
   localparam logic [TICKS_W-1:0]    DEF_LONG_PHASE_TICKS    = 8'd80;
   localparam logic [TICKS_W-1:0]    DEF_SHORT_REVERSE_TICKS = 8'd50;
   localparam logic [TICKS_W-1:0]    DEF_SHORT_WAIT_TICKS    = 8'd70;
   localparam logic [TICKS_W-1:0]    DEF_FAST_FEED_TICKS     = 8'd80;
   localparam logic [TICKS_W-1:0]    SLOW_FEED_TICKS         = 8'd40;

   // output modes
   localparam logic [MODE_W-1:0] MODE_NORMAL  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WAIT    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FAST    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SLOW    = 3'd4;

   // long sequence phases
   localparam logic [1:0] LONG_IDLE    = 2'd0;
   localparam logic [1:0] LONG_REVERSE = 2'd1;
   localparam logic [1:0] LONG_WAIT    = 2'd2;

   // short sequence phases
   localparam logic [2:0] SHORT_IDLE    = 3'd0;
   localparam logic [2:0] SHORT_REVERSE = 3'd1;
   localparam logic [2:0] SHORT_WAIT    = 3'd2;
   localparam logic [2:0] SHORT_FAST    = 3'd3;
   localparam logic [2:0] SHORT_SLOW    = 3'd4;

endpackage
`default_nettype wire

### rtl/feeder_jam_recovery_unit.sv
// A request passes through the input register and the result register to its response.
// One request per cycle unless stalled; detectors and sequencer update in one logic pass.
// A stalled response holds the pipe; the input register then takes a request only if empty.
// Reset clears the counters, phases, timer and flag and restores register defaults.
// Top level of the feeder jam recovery unit: jam detectors and recovery sequencer.
`default_nettype none
module feeder_jam_recovery_unit
   import fjr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [15:0] current_command, [16] sensor_level, [17] missed_shot, [18] enabled, [23:19] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [2:0] recovery_mode, [3] fast_feed, [7:4] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [LIMIT_W-1:0]    jam_current_limit_ff;
   logic [LIMIT_W-1:0]    hard_current_limit_ff;
   logic [JAM_CNT_W-1:0]  jam_time_limit_ff;
   logic [HARD_CNT_W-1:0] hard_time_limit_ff;
   logic [TICKS_W-1:0]    long_phase_ticks_ff;
   logic [TICKS_W-1:0]    short_reverse_ticks_ff;
   logic [TICKS_W-1:0]    short_wait_ticks_ff;
   logic [TICKS_W-1:0]    fast_feed_ticks_ff;

   // pipe
   logic                  in_valid_ff;
   logic [CUR_W-1:0]      in_current_ff;
   logic                  in_sensor_ff;
   logic                  in_missed_ff;
   logic                  in_enabled_ff;
   logic                  out_valid_ff;
   logic [MODE_W-1:0]     out_mode_ff;
   logic                  out_fast_ff;
   logic                  advance;
   logic                  fire;

   // sequencer state
   logic [JAM_CNT_W-1:0]  jam_count_ff,  jam_count_in;
   logic [HARD_CNT_W-1:0] hard_count_ff, hard_count_in;
   logic [1:0]            long_phase_ff, long_phase_in;
   logic [2:0]            short_phase_ff, short_phase_in;
   logic [TICKS_W-1:0]    phase_timer_ff, phase_timer_in;
   logic                  fast_flag_ff,  fast_flag_in;
   logic [MODE_W-1:0]     mode_in;

   logic                  over_jam;
   logic                  over_hard;
   logic [TICKS_W:0]      long_tick;
   logic [TICKS_W:0]      short_tick;
   logic [TICKS_W-1:0]    short_lim;

   // returns {expired, next timer}
   function automatic logic [TICKS_W:0] tick_timer(input logic [TICKS_W-1:0] t,
                                                  input logic [TICKS_W-1:0] lim);
      logic [TICKS_W-1:0] inc;
      begin
         inc = (t == {TICKS_W{1'b1}}) ? t : t + 1'b1;
         if (inc > lim) begin
            tick_timer = {1'b1, {TICKS_W{1'b0}}};
         end else begin
            tick_timer = {1'b0, inc};
         end
      end
   endfunction

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign fire       = in_valid_ff && advance;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-MODE_W-1){1'b0}}, out_fast_ff, out_mode_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         jam_current_limit_ff   <= DEF_JAM_CURRENT_LIMIT;
         hard_current_limit_ff  <= DEF_HARD_CURRENT_LIMIT;
         jam_time_limit_ff      <= DEF_JAM_TIME_LIMIT;
         hard_time_limit_ff     <= DEF_HARD_TIME_LIMIT;
         long_phase_ticks_ff    <= DEF_LONG_PHASE_TICKS;
         short_reverse_ticks_ff <= DEF_SHORT_REVERSE_TICKS;
         short_wait_ticks_ff    <= DEF_SHORT_WAIT_TICKS;
         fast_feed_ticks_ff     <= DEF_FAST_FEED_TICKS;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_JAM_CURRENT_LIMIT:   jam_current_limit_ff   <= csr_wdata[LIMIT_W-1:0];
            REG_HARD_CURRENT_LIMIT:  hard_current_limit_ff  <= csr_wdata[LIMIT_W-1:0];
            REG_JAM_TIME_LIMIT:      jam_time_limit_ff      <= csr_wdata[JAM_CNT_W-1:0];
            REG_HARD_TIME_LIMIT:     hard_time_limit_ff     <= csr_wdata[HARD_CNT_W-1:0];
            REG_LONG_PHASE_TICKS:    long_phase_ticks_ff    <= csr_wdata[TICKS_W-1:0];
            REG_SHORT_REVERSE_TICKS: short_reverse_ticks_ff <= csr_wdata[TICKS_W-1:0];
            REG_SHORT_WAIT_TICKS:    short_wait_ticks_ff    <= csr_wdata[TICKS_W-1:0];
            REG_FAST_FEED_TICKS:     fast_feed_ticks_ff     <= csr_wdata[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_current_ff <= req_tdata[CUR_W-1:0];
         in_sensor_ff  <= req_tdata[CUR_W];
         in_missed_ff  <= req_tdata[CUR_W+1];
         in_enabled_ff <= req_tdata[CUR_W+2];
      end
   end

   assign over_jam  = $signed(in_current_ff) > $signed({1'b0, jam_current_limit_ff});
   assign over_hard = $signed(in_current_ff) > $signed({1'b0, hard_current_limit_ff});

   always_comb begin
      jam_count_in   = jam_count_ff;
      hard_count_in  = hard_count_ff;
      long_phase_in  = long_phase_ff;
      short_phase_in = short_phase_ff;
      phase_timer_in = phase_timer_ff;
      fast_flag_in   = fast_flag_ff;
      mode_in        = MODE_NORMAL;
      long_tick      = '0;
      short_tick     = '0;
      short_lim      = SLOW_FEED_TICKS;

      if (in_enabled_ff) begin
         if (in_missed_ff) begin
            short_phase_in = SHORT_REVERSE;
         end

         if (over_jam) begin
            if (jam_count_in != {JAM_CNT_W{1'b1}}) begin
               jam_count_in = jam_count_in + 1'b1;
            end
            if (jam_count_in > jam_time_limit_ff) begin
               long_phase_in = LONG_REVERSE;
               jam_count_in  = '0;
            end
            if (over_hard) begin
               if (hard_count_in != {HARD_CNT_W{1'b1}}) begin
                  hard_count_in = hard_count_in + 1'b1;
               end
               if (hard_count_in > hard_time_limit_ff && !in_sensor_ff) begin
                  short_phase_in = SHORT_REVERSE;
                  hard_count_in  = '0;
               end
            end
         end else begin
            jam_count_in  = '0;
            hard_count_in = '0;
         end

         // long sequence takes the timer first
         if (long_phase_in == LONG_REVERSE || long_phase_in == LONG_WAIT) begin
            long_tick      = tick_timer(phase_timer_in, long_phase_ticks_ff);
            phase_timer_in = long_tick[TICKS_W-1:0];
            if (long_tick[TICKS_W]) begin
               if (long_phase_in == LONG_REVERSE) begin
                  long_phase_in = LONG_WAIT;
               end else begin
                  long_phase_in = LONG_IDLE;
                  fast_flag_in  = 1'b1;
               end
            end
         end

         unique case (short_phase_in)
            SHORT_REVERSE: short_lim = short_reverse_ticks_ff;
            SHORT_WAIT:    short_lim = short_wait_ticks_ff;
            SHORT_FAST:    short_lim = fast_feed_ticks_ff;
            default:       short_lim = SLOW_FEED_TICKS;
         endcase

         if (short_phase_in >= SHORT_REVERSE && short_phase_in <= SHORT_SLOW) begin
            short_tick     = tick_timer(phase_timer_in, short_lim);
            phase_timer_in = short_tick[TICKS_W-1:0];
            if (short_tick[TICKS_W]) begin
               short_phase_in = (short_phase_in == SHORT_SLOW) ? SHORT_IDLE
                                                               : short_phase_in + 1'b1;
            end
         end

         priority if (long_phase_in == LONG_REVERSE || short_phase_in == SHORT_REVERSE) begin
            mode_in = MODE_REVERSE;
         end else if (long_phase_in == LONG_WAIT || short_phase_in == SHORT_WAIT) begin
            mode_in = MODE_WAIT;
         end else if (short_phase_in == SHORT_FAST) begin
            mode_in = MODE_FAST;
         end else if (short_phase_in == SHORT_SLOW) begin
            mode_in = MODE_SLOW;
         end else begin
            mode_in = MODE_NORMAL;
            if (!in_sensor_ff) begin
               fast_flag_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jam_count_ff   <= '0;
         hard_count_ff  <= '0;
         long_phase_ff  <= LONG_IDLE;
         short_phase_ff <= SHORT_IDLE;
         phase_timer_ff <= '0;
         fast_flag_ff   <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            jam_count_ff   <= jam_count_in;
            hard_count_ff  <= hard_count_in;
            long_phase_ff  <= long_phase_in;
            short_phase_ff <= short_phase_in;
            phase_timer_ff <= phase_timer_in;
            fast_flag_ff   <= fast_flag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_mode_ff <= mode_in;
         out_fast_ff <= fast_flag_in;
      end
   end

endmodule
`default_nettype wire

### rtl/fjr_checker.sv
// Port-level checker for the feeder jam recovery unit, bound to the top level.
`default_nettype none
module fjr_checker
   import fjr_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[MODE_W-1:0] <= MODE_SLOW)
      else $error("recovery mode out of range");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:MODE_W+1] == '0)
      else $error("response padding not zero");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // a fresh response follows an earlier accepted request, through the input and result registers
   a_no_rsp_without_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("response without request");

endmodule

bind feeder_jam_recovery_unit fjr_checker u_fjr_checker (.*);
`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the feeder jam recovery unit: predictor, stimulus and response check.
`timescale 1ns / 1ps
module tb
   import fjr_pkg::*;
();

   localparam int LIMIT_CYCLES = 400000;
   localparam int N_PHASES     = 12;

   typedef struct packed {
      logic        en;
      logic        missed;
      logic        sensor;
      logic [15:0] cur;
   } tick_req_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              ff;
   } tick_out_type;

   typedef struct packed {
      logic              chk;
      logic [MODE_W-1:0] mode;
      logic              ff;
      tick_req_type      req;
   } tick_row_type;

   typedef struct {
      logic [15:0] jam_cur, hard_cur, jam_time, hard_time;
      logic [15:0] long_t, srev_t, swait_t, ffeed_t;
   } limits_type;

   // directed rows: {check, mode, fast_feed, {enabled, missed_shot, sensor, current}}
   localparam tick_row_type DIR_ROWS [14] = '{
      '{1'b1, MODE_NORMAL,  1'b0, '{1'b1, 1'b0, 1'b1, 16'h0000}},
      '{1'b1, MODE_NORMAL,  1'b0, '{1'b1, 1'b0, 1'b0, 16'h8000}},
      '{1'b1, MODE_NORMAL,  1'b0, '{1'b0, 1'b0, 1'b1, 16'h7FFF}},
      '{1'b1, MODE_NORMAL,  1'b0, '{1'b0, 1'b1, 1'b0, 16'h7FFF}},
      '{1'b1, MODE_NORMAL,  1'b0, '{1'b1, 1'b0, 1'b1, 16'h7FFF}},
      '{1'b1, MODE_NORMAL,  1'b0, '{1'b1, 1'b0, 1'b0, 16'd4201}},
      '{1'b1, MODE_NORMAL,  1'b0, '{1'b1, 1'b0, 1'b0, 16'd4200}},
      '{1'b1, MODE_REVERSE, 1'b0, '{1'b1, 1'b1, 1'b1, 16'h0000}},
      '{1'b0, MODE_NORMAL,  1'b0, '{1'b1, 1'b0, 1'b0, 16'd16001}},
      '{1'b1, MODE_NORMAL,  1'b0, '{1'b0, 1'b0, 1'b0, 16'h0000}},
      '{1'b0, MODE_NORMAL,  1'b0, '{1'b1, 1'b1, 1'b1, 16'hFFFF}},
      '{1'b0, MODE_NORMAL,  1'b0, '{1'b1, 1'b1, 1'b0, 16'h5555}},
      '{1'b0, MODE_NORMAL,  1'b0, '{1'b1, 1'b0, 1'b1, 16'h2AAA}},
      '{1'b0, MODE_NORMAL,  1'b0, '{1'b1, 1'b0, 1'b0, 16'd16000}}
   };

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = REG_JAM_CURRENT_LIMIT;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   feeder_jam_recovery_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // predictor copy of registers and state
   logic [LIMIT_W-1:0]    jam_lim, hard_lim;
   logic [JAM_CNT_W-1:0]  jam_tlim, jam_cnt;
   logic [HARD_CNT_W-1:0] hard_tlim, hard_cnt;
   logic [TICKS_W-1:0]    long_ticks, srev_ticks, swait_ticks, ffeed_ticks, ph_timer;
   logic [1:0]            long_ph;
   logic [2:0]            short_ph;
   logic                  ff_flag;

   tick_out_type recovery_expect_q [$];
   int        mismatches = 0;
   int        cycle_count = 0;
   bit        steady = 1'b0;
   int        regime = 0;
   int        regime_left = 0;

   function automatic void recovery_reset();
      jam_lim     = DEF_JAM_CURRENT_LIMIT;
      hard_lim    = DEF_HARD_CURRENT_LIMIT;
      jam_tlim    = DEF_JAM_TIME_LIMIT;
      hard_tlim   = DEF_HARD_TIME_LIMIT;
      long_ticks  = DEF_LONG_PHASE_TICKS;
      srev_ticks  = DEF_SHORT_REVERSE_TICKS;
      swait_ticks = DEF_SHORT_WAIT_TICKS;
      ffeed_ticks = DEF_FAST_FEED_TICKS;
      jam_cnt     = '0;
      hard_cnt    = '0;
      long_ph     = LONG_IDLE;
      short_ph    = SHORT_IDLE;
      ph_timer    = '0;
      ff_flag     = 1'b0;
   endfunction

   function automatic void recovery_cfg_write(logic [CSR_IDX_W-1:0] idx,
                                              logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_JAM_CURRENT_LIMIT:   jam_lim     = val[LIMIT_W-1:0];
         REG_HARD_CURRENT_LIMIT:  hard_lim    = val[LIMIT_W-1:0];
         REG_JAM_TIME_LIMIT:      jam_tlim    = val[JAM_CNT_W-1:0];
         REG_HARD_TIME_LIMIT:     hard_tlim   = val[HARD_CNT_W-1:0];
         REG_LONG_PHASE_TICKS:    long_ticks  = val[TICKS_W-1:0];
         REG_SHORT_REVERSE_TICKS: srev_ticks  = val[TICKS_W-1:0];
         REG_SHORT_WAIT_TICKS:    swait_ticks = val[TICKS_W-1:0];
         REG_FAST_FEED_TICKS:     ffeed_ticks = val[TICKS_W-1:0];
         default: ;
      endcase
   endfunction

   // shared timer: saturates at 255, clears once it passes the phase length
   function automatic bit phase_timer_done(logic [TICKS_W-1:0] len);
      if (ph_timer != 8'hFF) ph_timer++;
      if (ph_timer > len) begin
         ph_timer = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic tick_out_type recovery_tick(tick_req_type r);
      tick_out_type o;
      int        c;
      c = int'($signed(r.cur));
      o.mode = MODE_NORMAL;
      if (r.en) begin
         if (r.missed) short_ph = SHORT_REVERSE;
         if (c > int'(jam_lim)) begin
            if (jam_cnt != '1) jam_cnt++;
            if (jam_cnt > jam_tlim) begin
               long_ph = LONG_REVERSE;
               jam_cnt = '0;
            end
            if (c > int'(hard_lim)) begin
               if (hard_cnt != '1) hard_cnt++;
               if (hard_cnt > hard_tlim && !r.sensor) begin
                  short_ph = SHORT_REVERSE;
                  hard_cnt = '0;
               end
            end
         end else begin
            jam_cnt  = '0;
            hard_cnt = '0;
         end
         case (long_ph)
            LONG_REVERSE: if (phase_timer_done(long_ticks)) long_ph = LONG_WAIT;
            LONG_WAIT: if (phase_timer_done(long_ticks)) begin
               long_ph = LONG_IDLE;
               ff_flag = 1'b1;
            end
            default: ;
         endcase
         case (short_ph)
            SHORT_REVERSE: if (phase_timer_done(srev_ticks)) short_ph = SHORT_WAIT;
            SHORT_WAIT:    if (phase_timer_done(swait_ticks)) short_ph = SHORT_FAST;
            SHORT_FAST:    if (phase_timer_done(ffeed_ticks)) short_ph = SHORT_SLOW;
            SHORT_SLOW:    if (phase_timer_done(SLOW_FEED_TICKS)) short_ph = SHORT_IDLE;
            default: ;
         endcase
         if (long_ph == LONG_REVERSE || short_ph == SHORT_REVERSE) o.mode = MODE_REVERSE;
         else if (long_ph == LONG_WAIT || short_ph == SHORT_WAIT) o.mode = MODE_WAIT;
         else if (short_ph == SHORT_FAST) o.mode = MODE_FAST;
         else if (short_ph == SHORT_SLOW) o.mode = MODE_SLOW;
         else if (!r.sensor) ff_flag = 1'b0;
      end
      o.ff = ff_flag;
      return o;
   endfunction

   function automatic int unsigned idle_draw();
      if (steady || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 17);
   endfunction

   function automatic logic [15:0] above(int lim);
      if (lim >= 32767) return 16'h7FFF;
      return 16'($urandom_range(lim + 1, 32767));
   endfunction

   task automatic issue(input tick_req_type r, input bit typed,
                        input logic [MODE_W-1:0] want_mode, input logic want_ff);
      tick_out_type p;
      int unsigned  gap;
      gap = idle_draw();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(r);
      do @(posedge clock); while (req_tready !== 1'b1);
      p = recovery_tick(r);
      if (typed) begin
         p.mode = want_mode;
         p.ff   = want_ff;
      end
      recovery_expect_q.push_back(p);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (recovery_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      recovery_cfg_write(idx, val);
   endtask

   task automatic load_limits(input limits_type l);
      write_reg(REG_JAM_CURRENT_LIMIT, l.jam_cur);
      write_reg(REG_HARD_CURRENT_LIMIT, l.hard_cur);
      write_reg(REG_JAM_TIME_LIMIT, l.jam_time);
      write_reg(REG_HARD_TIME_LIMIT, l.hard_time);
      write_reg(REG_LONG_PHASE_TICKS, l.long_t);
      write_reg(REG_SHORT_REVERSE_TICKS, l.srev_t);
      write_reg(REG_SHORT_WAIT_TICKS, l.swait_t);
      write_reg(REG_FAST_FEED_TICKS, l.ffeed_t);
      csr_we <= 1'b0;
   endtask

   task automatic draw_limits(input int p, output limits_type l);
      if (p == 0) begin
         l = '{default: 16'h0000};
      end else if (p == 1) begin
         // the jam counter runs into saturation; 255-tick phases never end
         l = '{16'hFFFF, 16'h7FFF, 16'h03FF, 16'hFFFF, 16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF};
         l.jam_cur = 16'h0000;
      end else begin
         l.jam_cur   = 16'($urandom_range(0, 3000));
         l.hard_cur  = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 32767))
                     : 16'(l.jam_cur + $urandom_range(0, 4000));
         l.jam_time  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 1023))
                     : 16'($urandom_range(0, 12));
         l.hard_time = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                     : 16'($urandom_range(0, 12));
         l.long_t    = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 255))
                     : 16'($urandom_range(0, 8));
         l.srev_t    = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 255))
                     : 16'($urandom_range(0, 8));
         l.swait_t   = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 255))
                     : 16'($urandom_range(0, 8));
         l.ffeed_t   = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 255))
                     : 16'($urandom_range(0, 8));
      end
   endtask

   // regimes: 0 hard jam, 1 sustained overcurrent, 2 low current, 3 noise
   task automatic next_item(input bit sustain, output tick_req_type r);
      int hi;
      if (regime_left == 0) begin
         regime      = sustain ? 1 : $urandom_range(0, 3);
         regime_left = $urandom_range(1, 30);
         steady      = ($urandom_range(0, 3) == 0);
      end
      regime_left--;
      hi       = (hard_lim > jam_lim) ? int'(hard_lim) : int'(jam_lim);
      r.en     = sustain || ($urandom_range(0, 9) != 0);
      r.missed = ($urandom_range(0, sustain ? 39 : 19) == 0);
      r.sensor = 1'($urandom_range(0, 1));
      case (regime)
         0: begin
            r.cur    = above(hi);
            r.sensor = ($urandom_range(0, 3) == 0);
         end
         1: r.cur = above(int'(jam_lim));
         2: r.cur = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(32768, 65535))
                  : 16'($urandom_range(0, int'(jam_lim)));
         default: begin
            r.cur    = 16'($urandom_range(0, 65535));
            r.en     = 1'($urandom_range(0, 1));
            r.missed = 1'($urandom_range(0, 1));
         end
      endcase
   endtask

   initial begin : rsp_pacer
      int unsigned stall;
      forever begin
         stall = idle_draw();
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   always @(posedge clock) begin : rsp_check
      tick_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (recovery_expect_q.size() == 0) begin
            $display("%0t ERROR unexpected response: expected none, actual %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = recovery_expect_q.pop_front();
            if (rsp_tdata[2:0] !== want.mode) begin
               $display("%0t ERROR recovery_mode: expected %0d, actual %0d",
                        $time, want.mode, rsp_tdata[2:0]);
               mismatches++;
            end
            if (rsp_tdata[3] !== want.ff) begin
               $display("%0t ERROR fast_feed: expected %0d, actual %0d",
                        $time, want.ff, rsp_tdata[3]);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("%0t ERROR timeout with %0d responses outstanding",
                  $time, recovery_expect_q.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      tick_req_type r;
      limits_type   l;
      int           n;
      recovery_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      foreach (DIR_ROWS[i])
         issue(DIR_ROWS[i].req, DIR_ROWS[i].chk, DIR_ROWS[i].mode, DIR_ROWS[i].ff);
      drain();
      for (int p = 0; p < N_PHASES; p++) begin
         draw_limits(p, l);
         load_limits(l);
         regime_left = 0;
         n = (p == 1) ? 1100 : 49;
         repeat (n) begin
            next_item(p == 1, r);
            issue(r, 1'b0, MODE_NORMAL, 1'b0);
         end
         drain();
      end
      if (mismatches == 0 && recovery_expect_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### sim.f
rtl/fjr_pkg.sv
rtl/feeder_jam_recovery_unit.sv
rtl/fjr_checker.sv
tb/sv/tb.sv
